// ----- design/lsrs_pkg.sv -----
// Shared types, constants and helpers of the link scan round sequencer.
package lsrs_pkg;

    localparam int NODES   = 16;
    localparam int SEQ_MOD = 1024;

    localparam int NODE_W = 5;
    localparam int SLOT_W = $clog2(NODES);
    localparam int SEQ_W  = $clog2(SEQ_MOD);

    localparam logic [NODE_W-1:0] NODE_INDEX_RESET = 5'd4;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_NODE_INDEX = 1'b0;

    // input command codes
    localparam logic CMD_LINK    = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    // control message kinds
    localparam logic [1:0] KIND_SCAN    = 2'd0;
    localparam logic [1:0] KIND_CHECK   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // result actions
    localparam logic [1:0] ACT_NOTE    = 2'd0;
    localparam logic [1:0] ACT_REPORT  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // decoded operation of an input word
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_NOTE    = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // result selection for the output register
    localparam logic [1:0] SEL_NOTE    = 2'd0;
    localparam logic [1:0] SEL_FINAL   = 2'd1;
    localparam logic [1:0] SEL_REPORT  = 2'd2;
    localparam logic [1:0] SEL_RESTART = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic               addressed_to_self;
        logic [NODE_W-1:0]  src_node;
        logic signed [7:0]  rssi;
        logic [1:0]         msg_kind;
        logic [9:0]         pkt_id;
    } lsrs_in_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [NODE_W-1:0]  dest_node;
        logic [9:0]         seq_id;
        logic [3:0]         slot;
        logic signed [7:0]  value;
        logic               last;
    } lsrs_out_t;

    typedef struct packed {
        logic       accept;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       load;
        logic [1:0] sel;
    } lsrs_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       skip;
        logic       cnt_last;
        logic       out_free;
    } lsrs_status_t;

    function automatic logic [NODES-1:0] node_bit(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] m;
        logic [NODES-1:0]  b;
        m = n - NODE_W'(1);
        b = '0;
        if (n != '0 && n <= NODE_W'(NODES))
        begin
            b[m[SLOT_W-1:0]] = 1'b1;
        end
        return b;
    endfunction

endpackage

// ----- design/link_scan_round_sequencer.sv -----
// Top level of the link scan round sequencer: register port and submodules.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_word (lsrs_in_t)
//   out       output     out_valid/out_stall out_word (lsrs_out_t)
//   config    input      APB psel/penable    node_index at byte address 0
//
// An input word is taken only while the controller is idle. A report steps a
// slot counter once per node, sending one word per slot; a note round steps it
// likewise and adds a final note. One output register sets the pace. Reset is
// asynchronous and clears the round state, though not the held sequence number
// or the output word. Output stalls hold the counter, except on skipped peers.
module link_scan_round_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lsrs_pkg::lsrs_in_t                in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lsrs_pkg::lsrs_out_t               out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsrs_pkg::PADDR_W-1:0]      paddr,
    input  logic [lsrs_pkg::PDATA_W-1:0]      pwdata,
    output logic [lsrs_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [lsrs_pkg::NODE_W-1:0] node_index_reg;
    logic                        reg_sel;
    lsrs_pkg::lsrs_cmd_t         cmd;
    lsrs_pkg::lsrs_status_t      st;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[lsrs_pkg::PADDR_W-1:2] == lsrs_pkg::REG_NODE_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_index_reg <= lsrs_pkg::NODE_INDEX_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            node_index_reg <= pwdata[lsrs_pkg::NODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata[lsrs_pkg::NODE_W-1:0] = node_index_reg;
        end
    end

    lsrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    lsrs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (in_word),
        .node_index (node_index_reg),
        .cmd        (cmd),
        .st         (st),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_word   (out_word)
    );

endmodule

// ----- design/lsrs_ctrl.sv -----
// Controller state machine of the link scan round sequencer.
module lsrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lsrs_pkg::lsrs_status_t st,
    output lsrs_pkg::lsrs_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_NOTE    = 3'd1;
    localparam logic [2:0] S_FINAL   = 3'd2;
    localparam logic [2:0] S_REPORT  = 3'd3;
    localparam logic [2:0] S_RESTART = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.cnt_clr = 1'b0;
        cmd.cnt_inc = 1'b0;
        cmd.load    = 1'b0;
        cmd.sel     = lsrs_pkg::SEL_NOTE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    unique case (st.op)
                        lsrs_pkg::OP_NOTE:    state_next = S_NOTE;
                        lsrs_pkg::OP_REPORT:  state_next = S_REPORT;
                        lsrs_pkg::OP_RESTART: state_next = S_RESTART;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_NOTE:
            begin
                // skipped peers advance without waiting on the output side
                if (st.skip || st.out_free)
                begin
                    cmd.cnt_inc = 1'b1;
                    cmd.load    = !st.skip;
                    cmd.sel     = lsrs_pkg::SEL_NOTE;
                    if (st.cnt_last)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (st.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = lsrs_pkg::SEL_FINAL;
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (st.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.sel     = lsrs_pkg::SEL_REPORT;
                    if (st.cnt_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESTART:
            begin
                if (st.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = lsrs_pkg::SEL_RESTART;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> st.out_free)
        else $error("result loaded while output register busy");

    a_note_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NOTE && st.cnt_last && (st.skip || st.out_free))
        |=> state_reg == S_FINAL)
        else $error("note round did not end with its final note");

    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && st.out_free) |=> (state_reg == S_IDLE && !in_stall))
        else $error("sequencer not idle after final note");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (state_reg == S_IDLE && !cmd.load))
        else $error("word accepted outside idle");
`endif

endmodule

// ----- design/lsrs_dp.sv -----
// Datapath: round state, RSSI slots, sequence counters and output register.
module lsrs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsrs_pkg::lsrs_in_t                  in_word,
    input  logic [lsrs_pkg::NODE_W-1:0]         node_index,
    input  lsrs_pkg::lsrs_cmd_t                 cmd,
    output lsrs_pkg::lsrs_status_t              st,
    input  logic                                out_stall,
    output logic                                out_valid,
    output lsrs_pkg::lsrs_out_t                 out_word
);

    localparam int NW = lsrs_pkg::NODE_W;
    localparam int SW = lsrs_pkg::SLOT_W;
    localparam int QW = lsrs_pkg::SEQ_W;

    logic [lsrs_pkg::NODES-1:0] seen_reg;
    logic signed [7:0]          rssi_reg [lsrs_pkg::NODES];
    logic [QW-1:0]              scan_exp_reg;
    logic [QW-1:0]              check_exp_reg;
    logic [QW-1:0]              note_seq_reg;
    logic [QW-1:0]              report_seq_reg;
    logic [QW-1:0]              run_seq_reg;
    logic [SW-1:0]              cnt_reg;
    logic                       out_valid_reg;
    lsrs_pkg::lsrs_out_t        out_word_reg;
    lsrs_pkg::lsrs_out_t        out_word_next;

    logic          idx_ok;
    logic          link_ok;
    logic          link_note;
    logic          ctl_ok;
    logic          scan_ok;
    logic          check_ok;
    logic          restart;
    logic [1:0]    op;
    logic [NW-1:0] src_m1;
    logic [SW-1:0] src_slot;
    logic [NW-1:0] peer;

    // decode the word at the input
    always_comb
    begin
        src_m1   = in_word.src_node - NW'(1);
        src_slot = src_m1[SW-1:0];
        idx_ok   = (node_index != '0) && (node_index <= NW'(lsrs_pkg::NODES));
        link_ok  = in_word.addressed_to_self && (in_word.cmd == lsrs_pkg::CMD_LINK)
                   && idx_ok && (in_word.src_node != '0)
                   && (in_word.src_node <= NW'(lsrs_pkg::NODES))
                   && (in_word.src_node != node_index) && !seen_reg[src_slot];
        link_note = link_ok
                    && (({1'b0, in_word.src_node} + (NW+1)'(1)) == {1'b0, node_index});
        ctl_ok   = in_word.addressed_to_self && (in_word.cmd == lsrs_pkg::CMD_CONTROL)
                   && (in_word.src_node == '0);
        restart  = ctl_ok && (in_word.msg_kind == lsrs_pkg::KIND_RESTART);
        scan_ok  = ctl_ok && idx_ok && (in_word.msg_kind == lsrs_pkg::KIND_SCAN)
                   && (in_word.pkt_id == scan_exp_reg);
        check_ok = ctl_ok && idx_ok && (in_word.msg_kind == lsrs_pkg::KIND_CHECK)
                   && (in_word.pkt_id == check_exp_reg);
        if (restart)
            op = lsrs_pkg::OP_RESTART;
        else if (link_note || scan_ok)
            op = lsrs_pkg::OP_NOTE;
        else if (check_ok)
            op = lsrs_pkg::OP_REPORT;
        else
            op = lsrs_pkg::OP_NONE;
    end

    // peer of the current count; skip self and successor in the note round
    always_comb
    begin
        st.op       = op;
        peer        = {{(NW-SW){1'b0}}, cnt_reg} + NW'(1);
        st.skip     = (peer == node_index)
                      || ({1'b0, peer} == ({1'b0, node_index} + (NW+1)'(1)));
        st.cnt_last = (cnt_reg == SW'(lsrs_pkg::NODES - 1));
        st.out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        out_word_next = '0;
        case (cmd.sel)
            lsrs_pkg::SEL_NOTE:
            begin
                out_word_next.action    = lsrs_pkg::ACT_NOTE;
                out_word_next.dest_node = peer;
                out_word_next.seq_id    = run_seq_reg;
            end
            lsrs_pkg::SEL_FINAL:
            begin
                out_word_next.action    = lsrs_pkg::ACT_NOTE;
                out_word_next.dest_node = (node_index < NW'(lsrs_pkg::NODES))
                                          ? node_index + NW'(1) : '0;
                out_word_next.seq_id    = run_seq_reg;
                out_word_next.last      = 1'b1;
            end
            lsrs_pkg::SEL_REPORT:
            begin
                out_word_next.action = lsrs_pkg::ACT_REPORT;
                out_word_next.seq_id = run_seq_reg;
                out_word_next.slot   = cnt_reg;
                out_word_next.value  = rssi_reg[cnt_reg];
                out_word_next.last   = st.cnt_last;
            end
            default:
            begin
                out_word_next.action = lsrs_pkg::ACT_RESTART;
                out_word_next.last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= lsrs_pkg::node_bit(lsrs_pkg::NODE_INDEX_RESET);
            scan_exp_reg   <= '0;
            check_exp_reg  <= '0;
            note_seq_reg   <= '0;
            report_seq_reg <= '0;
            for (int i = 0; i < lsrs_pkg::NODES; i++)
            begin
                rssi_reg[i] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            if (restart)
            begin
                seen_reg       <= lsrs_pkg::node_bit(node_index);
                scan_exp_reg   <= '0;
                check_exp_reg  <= '0;
                note_seq_reg   <= '0;
                report_seq_reg <= '0;
                for (int i = 0; i < lsrs_pkg::NODES; i++)
                begin
                    rssi_reg[i] <= '0;
                end
            end
            else
            begin
                if (link_ok)
                begin
                    rssi_reg[src_slot] <= in_word.rssi;
                    seen_reg[src_slot] <= 1'b1;
                end
                if (link_note || scan_ok)
                begin
                    note_seq_reg <= note_seq_reg + QW'(1);
                end
                if (scan_ok)
                begin
                    scan_exp_reg <= scan_exp_reg + QW'(1);
                end
                if (check_ok)
                begin
                    check_exp_reg  <= check_exp_reg + QW'(1);
                    report_seq_reg <= report_seq_reg + QW'(1);
                    seen_reg       <= lsrs_pkg::node_bit(node_index);
                end
            end
        end
    end

    // hold the sequence number of the round being sent
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            run_seq_reg <= check_ok ? report_seq_reg : note_seq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the link scan round sequencer: predicted note rounds, reports and restarts.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // Tracks the node's round state and the results each accepted word must yield.
    class round_tracker;
        lsrs_pkg::lsrs_out_t due_results[$];
        logic [4:0]        own_index;
        logic [15:0]       seen_mask;
        logic signed [7:0] rssi_slot[16];
        logic [9:0]        scan_next;
        logic [9:0]        check_next;
        logic [9:0]        note_count;
        logic [9:0]        report_count;
        int                errors;
        int                words;
        int                results;
        int                note_rounds;
        int                reports;
        int                restarts;

        function new();
            own_index   = lsrs_pkg::NODE_INDEX_RESET;
            errors      = 0;
            words       = 0;
            results     = 0;
            note_rounds = 0;
            reports     = 0;
            restarts    = 0;
            clear_round();
        endfunction

        function logic [15:0] bit_of(logic [4:0] n);
            logic [15:0] b;
            b = '0;
            if (n >= 1 && n <= lsrs_pkg::NODES)
            begin
                b[n - 1] = 1'b1;
            end
            return b;
        endfunction

        function void clear_round();
            seen_mask = bit_of(own_index);
            foreach (rssi_slot[i])
            begin
                rssi_slot[i] = '0;
            end
            scan_next    = '0;
            check_next   = '0;
            note_count   = '0;
            report_count = '0;
        endfunction

        function void set_index(logic [4:0] idx);
            own_index = idx;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void push(logic [1:0] act, logic [4:0] dest, logic [9:0] seq,
                           logic [3:0] slot, logic signed [7:0] value, logic last);
            lsrs_pkg::lsrs_out_t r;
            r.action    = act;
            r.dest_node = dest;
            r.seq_id    = seq;
            r.slot      = slot;
            r.value     = value;
            r.last      = last;
            due_results.push_back(r);
        endfunction

        // Every peer but self and successor in ascending order, successor (or base) last.
        function void note_round();
            for (int n = 1; n <= lsrs_pkg::NODES; n++)
            begin
                if (n != own_index && n != own_index + 1)
                begin
                    push(lsrs_pkg::ACT_NOTE, 5'(n), note_count, '0, '0, 1'b0);
                end
            end
            push(lsrs_pkg::ACT_NOTE,
                 (own_index < lsrs_pkg::NODES) ? 5'(own_index + 1) : 5'd0,
                 note_count, '0, '0, 1'b1);
            note_count++;
            note_rounds++;
        endfunction

        // Note an accepted input word; returns 1 if it changed state or caused results.
        function bit take_frame(lsrs_pkg::lsrs_in_t w);
            bit idx_ok;
            idx_ok = own_index >= 1 && own_index <= lsrs_pkg::NODES;
            words++;
            if (!w.addressed_to_self)
            begin
                return 1'b0;
            end
            if (w.cmd == lsrs_pkg::CMD_LINK)
            begin
                if (!idx_ok || w.src_node < 1 || w.src_node > lsrs_pkg::NODES
                    || w.src_node == own_index)
                begin
                    return 1'b0;
                end
                if ((seen_mask & bit_of(w.src_node)) != '0)
                begin
                    return 1'b0;
                end
                rssi_slot[w.src_node - 1] = w.rssi;
                if (w.src_node + 1 == own_index)
                begin
                    note_round();
                end
                seen_mask |= bit_of(w.src_node);
                return 1'b1;
            end
            if (w.src_node != '0)
            begin
                return 1'b0;
            end
            if (w.msg_kind == lsrs_pkg::KIND_RESTART)
            begin
                push(lsrs_pkg::ACT_RESTART, '0, '0, '0, '0, 1'b1);
                clear_round();
                restarts++;
                return 1'b1;
            end
            if (!idx_ok)
            begin
                return 1'b0;
            end
            if (w.msg_kind == lsrs_pkg::KIND_SCAN && w.pkt_id == scan_next)
            begin
                scan_next++;
                note_round();
                return 1'b1;
            end
            if (w.msg_kind == lsrs_pkg::KIND_CHECK && w.pkt_id == check_next)
            begin
                check_next++;
                for (int i = 0; i < lsrs_pkg::NODES; i++)
                begin
                    push(lsrs_pkg::ACT_REPORT, '0, report_count, 4'(i), rssi_slot[i],
                         i == lsrs_pkg::NODES - 1);
                end
                report_count++;
                seen_mask = bit_of(own_index);
                reports++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void flag(string field, logic [9:0] want, logic [9:0] seen);
            errors++;
            if (errors <= 40)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, field, want, seen);
            end
        endfunction

        function void match_result(lsrs_pkg::lsrs_out_t got);
            lsrs_pkg::lsrs_out_t e;
            results++;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                begin
                    $display("%0t: result word %h with nothing expected, got %h",
                             $time, got, got);
                end
                return;
            end
            e = due_results.pop_front();
            if (got.action !== e.action)
                flag("action", e.action, got.action);
            if (got.dest_node !== e.dest_node)
                flag("dest_node", e.dest_node, got.dest_node);
            if (got.seq_id !== e.seq_id)
                flag("seq_id", e.seq_id, got.seq_id);
            if (got.slot !== e.slot)
                flag("slot", e.slot, got.slot);
            if (got.value !== e.value)
                flag("value", e.value, got.value);
            if (got.last !== e.last)
                flag("last", e.last, got.last);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    lsrs_pkg::lsrs_in_t            in_word = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    lsrs_pkg::lsrs_out_t           out_word;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lsrs_pkg::PADDR_W-1:0]  paddr = '0;
    logic [lsrs_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [lsrs_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    round_tracker sb;
    bit           calm = 1'b0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           effective_words = 0;
    int           cycle_count = 0;

    link_scan_round_sequencer uut (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .in_word,
        .out_valid,
        .out_stall,
        .out_word,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic lsrs_pkg::lsrs_in_t frame_of(logic c, logic to_self, logic [4:0] src,
                                                    logic signed [7:0] rssi,
                                                    logic [1:0] kind, logic [9:0] pkt);
        lsrs_pkg::lsrs_in_t w;
        w.cmd               = c;
        w.addressed_to_self = to_self;
        w.src_node          = src;
        w.rssi              = rssi;
        w.msg_kind          = kind;
        w.pkt_id            = pkt;
        return w;
    endfunction

    // Mostly well-formed traffic with random content, the rest broken or pure noise.
    function automatic lsrs_pkg::lsrs_in_t pick_word();
        lsrs_pkg::lsrs_in_t w;
        int unsigned        r;
        logic [4:0]         src;
        r = $urandom_range(99);
        w = $bits(lsrs_pkg::lsrs_in_t)'($urandom);
        if (r < 45)
        begin
            src = 5'($urandom_range(1, lsrs_pkg::NODES));
            if ($urandom_range(3) == 0 && sb.own_index >= 2
                && sb.own_index <= lsrs_pkg::NODES)
            begin
                src = sb.own_index - 1;
            end
            w = frame_of(lsrs_pkg::CMD_LINK, 1'b1, src, 8'($urandom), 2'($urandom),
                         10'($urandom));
        end
        else if (r < 62)
        begin
            w = frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, '0, 8'($urandom),
                         lsrs_pkg::KIND_SCAN, sb.scan_next);
        end
        else if (r < 72)
        begin
            w = frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, '0, 8'($urandom),
                         lsrs_pkg::KIND_CHECK, sb.check_next);
        end
        else if (r < 75)
        begin
            w = frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, '0, 8'($urandom),
                         lsrs_pkg::KIND_RESTART, 10'($urandom));
        end
        else if (r < 82)
        begin
            // out-of-order sequence number
            w = frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, '0, 8'($urandom),
                         r[0] ? lsrs_pkg::KIND_SCAN : lsrs_pkg::KIND_CHECK,
                         (r[0] ? sb.scan_next : sb.check_next) + 10'($urandom_range(1, 5)));
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input lsrs_pkg::lsrs_in_t w, output bit took);
        while (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        took = sb.take_frame(w);
        if (took)
        begin
            effective_words++;
        end
        @(negedge clk);
    endtask

    task automatic run_random(input int target, input int max_words);
        int acted;
        int n;
        bit took;
        acted = 0;
        n = 0;
        while (acted < target && n < max_words)
        begin
            send_word(pick_word(), took);
            acted += took;
            n++;
        end
    endtask

    // Drop valid, wait for every expected word, then let in-flight work finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * lsrs_pkg::NODES + 8) @(negedge clk);
    endtask

    task automatic write_node_index(input logic [4:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lsrs_pkg::REG_NODE_INDEX, 2'b00};
        pwdata  <= lsrs_pkg::PDATA_W'(idx);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.set_index(idx);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.match_result(out_word);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("FAIL link_scan_round_sequencer");
        $finish;
    end

    initial
    begin
        bit took;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // node 4 out of reset: ignored senders, first and repeated readings, rounds
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b0, 5'd1, 8'sd10,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd0, 8'sd20,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd4, 8'sd30,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd31, 8'sd40,
                           KIND_OTHER, 10'd1023), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd1, 8'sh80,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd1, 8'sd7,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd16, 8'sd127,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd3, 8'shff,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd3, 8'sd9,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd5, 8'sd0,
                           lsrs_pkg::KIND_RESTART, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_SCAN, 10'd1023), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           KIND_OTHER, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_CHECK, 10'd1023), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_CHECK, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_LINK, 1'b1, 5'd3, 8'sd50,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b0, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_RESTART, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_RESTART, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_CHECK, 10'd0), took);
        send_word(frame_of(lsrs_pkg::CMD_CONTROL, 1'b1, 5'd0, 8'sd0,
                           lsrs_pkg::KIND_SCAN, 10'd0), took);
        run_random(50, 55);

        // first node: link frames never start a round
        settle();
        write_node_index(5'd1);
        run_random(30, 30);

        // final node: the round ends at the base; hold the output to back up the input
        settle();
        write_node_index(5'(lsrs_pkg::NODES));
        hold_requests++;
        run_random(40, 40);

        // index out of range: only restart does anything
        settle();
        write_node_index(5'd0);
        run_random(3, 10);
        settle();
        write_node_index(5'd31);
        run_random(3, 10);

        // mid-ring node, first without any idling on either side
        settle();
        write_node_index(5'($urandom_range(2, lsrs_pkg::NODES - 1)));
        calm = 1'b1;
        run_random(40, 25);
        calm = 1'b0;
        run_random(30, 20);

        settle();
        $display("Sent %0d words (%0d with effect) over six node indexes, checked %0d results.",
                 sb.words, effective_words, sb.results);
        $display("Saw %0d note rounds, %0d slot reports, %0d restarts, one long output hold.",
                 sb.note_rounds, sb.reports, sb.restarts);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS link_scan_round_sequencer");
        end
        else
        begin
            $display("FAIL link_scan_round_sequencer");
        end
        $finish;
    end

endmodule

// ----- link_scan_round_sequencer.f -----
design/lsrs_pkg.sv
design/lsrs_ctrl.sv
design/lsrs_dp.sv
design/link_scan_round_sequencer.sv
test/tb.sv
